// ----- rtl/core/msvf_pkg.sv -----
// Package for the memory snapshot value filter: config, job and result types,
// register indexes, compare codes and the window decode helpers.
// No dependencies.
package msvf_pkg;

  // Register indexes on the config write channel
  localparam logic [2:0] REG_WINDOW_BYTES  = 3'd0;
  localparam logic [2:0] REG_NUMBER_FORMAT = 3'd1;
  localparam logic [2:0] REG_COMPARE_OP    = 3'd2;
  localparam logic [2:0] REG_COMPARE_SRC   = 3'd3;
  localparam logic [2:0] REG_REFERENCE     = 3'd4;
  localparam logic [2:0] REG_BASE_ADDR     = 3'd5;
  localparam logic [2:0] REG_OTHER_BASE    = 3'd6;

  // Compare operations; the two remaining codes never match
  localparam logic [2:0] OP_LT = 3'd0;
  localparam logic [2:0] OP_LE = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_GE = 3'd3;
  localparam logic [2:0] OP_EQ = 3'd4;
  localparam logic [2:0] OP_NE = 3'd5;

  // number_format bits
  localparam int FMT_BIG_BIT = 0;
  localparam int FMT_BCD_BIT = 1;

  localparam logic [31:0] BCD_HI_WEIGHT = 32'd10000;

  typedef struct packed {
    logic [2:0]  window_bytes;
    logic [1:0]  number_format;
    logic [2:0]  compare_op;
    logic        compare_source;
    logic [31:0] reference_value;
    logic [31:0] base_address;
    logic [31:0] other_base_address;
  } cfg_t;

  typedef struct packed {
    logic [31:0] main_win;
    logic [31:0] other_win;
    logic [2:0]  width;
    logic [31:0] addr;
    logic        last;
    logic        full;
  } job_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        hit;
    logic        run_end;
  } result_t;

  // Clamp the programmed window size into 1..4
  function automatic logic [2:0] eff_width(logic [2:0] w);
    logic [2:0] r;
    case (w)
      3'd0: r = 3'd1;
      3'd1: r = 3'd1;
      3'd2: r = 3'd2;
      3'd3: r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Newest byte sits in the low byte of the window. Big-endian keeps the
  // lower w bytes as they stand, little-endian reverses them.
  function automatic logic [31:0] order_bytes(logic [31:0] win, logic [2:0] w, logic big);
    logic [31:0] v;
    if (big) begin
      case (w)
        3'd1: v = win & 32'h000000ff;
        3'd2: v = win & 32'h0000ffff;
        3'd3: v = win & 32'h00ffffff;
        default: v = win;
      endcase
    end else begin
      case (w)
        3'd1: v = {24'h0, win[7:0]};
        3'd2: v = {16'h0, win[7:0], win[15:8]};
        3'd3: v = {8'h0, win[7:0], win[15:8], win[23:16]};
        default: v = {win[7:0], win[15:8], win[23:16], win[31:24]};
      endcase
    end
    return v;
  endfunction

  // Weighted sum of four nibbles, digits above nine taken as they stand
  function automatic logic [14:0] bcd_quad(logic [15:0] n);
    logic [14:0] s;
    s = 15'(n[3:0]) + 15'(n[7:4]) * 15'd10 + 15'(n[11:8]) * 15'd100
      + 15'(n[15:12]) * 15'd1000;
    return s;
  endfunction

endpackage

// ----- rtl/core/msvf_front.sv -----
// Front end of the value filter: takes snapshot bytes, shifts the windows,
// tracks fill count and window start address, and queues one job per byte.
// Depends on msvf_pkg.
module msvf_front (
  input  logic               clk,
  input  logic               rst,
  input  msvf_pkg::cfg_t     cfg,
  input  logic               push,
  input  logic [7:0]         snapshot_byte,
  input  logic [7:0]         other_byte,
  input  logic               last_byte,
  input  logic               q_full,
  output logic               q_push,
  output msvf_pkg::job_t     q_data
);
  import msvf_pkg::*;

  logic [31:0] main_window;
  logic [31:0] other_window;
  logic [2:0]  fill_count;
  logic [31:0] window_start_address;

  logic [2:0]  w;
  logic [31:0] start;
  logic [2:0]  fill_next;
  logic [31:0] addr_next;

  always_comb begin
    w     = eff_width(cfg.window_bytes);
    start = (fill_count == 3'd0) ? cfg.base_address : window_start_address;
    if (fill_count < w) begin
      fill_next = fill_count + 3'd1;
      addr_next = start;
    end else begin
      // window already full: slide by one byte
      fill_next = w;
      addr_next = start + 32'd1;
    end
  end

  assign q_push = push && !q_full;

  always_comb begin
    q_data.main_win  = {main_window[23:0], snapshot_byte};
    q_data.other_win = {other_window[23:0], other_byte};
    q_data.width     = w;
    q_data.addr      = addr_next;
    q_data.last      = last_byte;
    q_data.full      = (fill_next >= w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_window          <= '0;
      other_window         <= '0;
      fill_count           <= '0;
      window_start_address <= '0;
    end else if (q_push) begin
      main_window          <= q_data.main_win;
      other_window         <= q_data.other_win;
      window_start_address <= addr_next;
      fill_count           <= last_byte ? 3'd0 : fill_next;
    end
  end

endmodule

// ----- rtl/core/msvf_queue.sv -----
// Job queue between the front and back ends of the value filter.
// Depends on msvf_pkg.
module msvf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  msvf_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output msvf_pkg::job_t rd_data,
  output logic           valid
);
  import msvf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/msvf_back.sv -----
// Back end of the value filter: byte ordering and BCD partial sums, BCD
// combine, compare, and a two-entry result buffer toward the output ports.
// Depends on msvf_pkg.
module msvf_back (
  input  logic           clk,
  input  logic           rst,
  input  msvf_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  msvf_pkg::job_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [31:0]    match_address,
  output logic           hit,
  output logic           run_end
);
  import msvf_pkg::*;

  // stage 1: ordered bytes and BCD half sums
  logic        v1;
  logic [31:0] s1_a_raw, s1_b_raw;
  logic [14:0] s1_a_lo, s1_a_hi, s1_b_lo, s1_b_hi;
  logic [31:0] s1_addr;
  logic        s1_last, s1_full;

  // stage 2: decoded values
  logic        v2;
  logic [31:0] s2_a, s2_b;
  logic [31:0] s2_addr;
  logic        s2_last, s2_full;

  // result buffer
  result_t     res [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  ocnt;

  logic [31:0] a_ord, b_ord;
  logic [31:0] a_bcd, b_bcd;
  logic [31:0] operand;
  logic        enable;
  logic        match;
  logic        produce;
  logic        pop_fire;
  logic        room;
  logic        adv2, load2, load1;
  result_t     res_in;

  always_comb begin
    a_ord = order_bytes(q_data.main_win, q_data.width, cfg.number_format[FMT_BIG_BIT]);
    b_ord = order_bytes(q_data.other_win, q_data.width, cfg.number_format[FMT_BIG_BIT]);
    a_bcd = 32'(s1_a_hi) * BCD_HI_WEIGHT + 32'(s1_a_lo);
    b_bcd = 32'(s1_b_hi) * BCD_HI_WEIGHT + 32'(s1_b_lo);
  end

  always_comb begin
    operand = cfg.compare_source ? s2_b : cfg.reference_value;
    enable  = s2_full && (!cfg.compare_source ||
                          (cfg.base_address == cfg.other_base_address));
    case (cfg.compare_op)
      OP_LT:   match = s2_a <  operand;
      OP_LE:   match = s2_a <= operand;
      OP_GT:   match = s2_a >  operand;
      OP_GE:   match = s2_a >= operand;
      OP_EQ:   match = s2_a == operand;
      OP_NE:   match = s2_a != operand;
      default: match = 1'b0;
    endcase
    res_in.hit     = enable && match;
    res_in.addr    = res_in.hit ? s2_addr : 32'd0;
    res_in.run_end = s2_last;
    produce        = res_in.hit || s2_last;
  end

  assign empty    = (ocnt == 2'd0);
  assign pop_fire = pop && !empty;
  assign room     = (ocnt != 2'd2) || pop_fire;
  // drop items that yield no result without waiting for buffer space
  assign adv2     = v2 && (!produce || room);
  assign load2    = v1 && (!v2 || adv2);
  assign load1    = q_valid && (!v1 || load2);
  assign q_pop    = load1;

  assign match_address = res[rd_ptr].addr;
  assign hit           = res[rd_ptr].hit;
  assign run_end       = res[rd_ptr].run_end;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_a_raw <= a_ord;
      s1_b_raw <= b_ord;
      s1_a_lo  <= bcd_quad(a_ord[15:0]);
      s1_a_hi  <= bcd_quad(a_ord[31:16]);
      s1_b_lo  <= bcd_quad(b_ord[15:0]);
      s1_b_hi  <= bcd_quad(b_ord[31:16]);
      s1_addr  <= q_data.addr;
      s1_last  <= q_data.last;
      s1_full  <= q_data.full;
    end
    if (load2) begin
      s2_a    <= cfg.number_format[FMT_BCD_BIT] ? a_bcd : s1_a_raw;
      s2_b    <= cfg.number_format[FMT_BCD_BIT] ? b_bcd : s1_b_raw;
      s2_addr <= s1_addr;
      s2_last <= s1_last;
      s2_full <= s1_full;
    end
    if (adv2 && produce) begin
      res[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      ocnt   <= 2'd0;
    end else begin
      if (load1) begin
        v1 <= 1'b1;
      end else if (load2) begin
        v1 <= 1'b0;
      end
      if (load2) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2 && produce) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= !rd_ptr;
      end
      if ((adv2 && produce) && !pop_fire) begin
        ocnt <= ocnt + 2'd1;
      end else if (pop_fire && !(adv2 && produce)) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/memory_snapshot_value_filter.sv -----
// Memory snapshot value filter, top level: config registers, front end,
// job queue and back end. Depends on msvf_pkg, msvf_front, msvf_queue, msvf_back.
// A byte taken passes the job queue, the ordering stage, the decode stage and the compare
// into the result buffer before its result shows on the output ports.
// Throughput: one byte per cycle, kept while the result side pops every cycle.
// Reset (synchronous, rst high) restores register defaults and empties all queues.
module memory_snapshot_value_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  snapshot_byte,
  input  logic [7:0]  other_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] match_address,
  output logic        hit,
  output logic        run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import msvf_pkg::*;

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_wr_data, q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_bytes       <= 3'd1;
      cfg.number_format      <= 2'd0;
      cfg.compare_op         <= OP_EQ;
      cfg.compare_source     <= 1'b0;
      cfg.reference_value    <= 32'd0;
      cfg.base_address       <= 32'd0;
      cfg.other_base_address <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_BYTES:  cfg.window_bytes       <= cfg_data[2:0];
        REG_NUMBER_FORMAT: cfg.number_format      <= cfg_data[1:0];
        REG_COMPARE_OP:    cfg.compare_op         <= cfg_data[2:0];
        REG_COMPARE_SRC:   cfg.compare_source     <= cfg_data[0];
        REG_REFERENCE:     cfg.reference_value    <= cfg_data;
        REG_BASE_ADDR:     cfg.base_address       <= cfg_data;
        REG_OTHER_BASE:    cfg.other_base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  msvf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .snapshot_byte (snapshot_byte),
    .other_byte    (other_byte),
    .last_byte     (last_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  msvf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .valid   (q_valid)
  );

  msvf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .match_address (match_address),
    .hit           (hit),
    .run_end       (run_end)
  );

endmodule

// ----- rtl/core/msvf_checker.sv -----
// Port-level checks for the memory snapshot value filter, bound to the top level.
// Depends on memory_snapshot_value_filter.
module msvf_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] match_address,
  input logic        hit,
  input logic        run_end
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a result without a match carries a zero address
  a_miss_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit) |-> (match_address == 32'd0))
    else $error("non-hit result with nonzero address");

  // every result that is shown reports a match or ends a run
  a_result_reason: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (hit || run_end))
    else $error("result with neither hit nor run end");

  // hold a waiting result until it is popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(match_address) && $stable(hit)
                          && $stable(run_end)))
    else $error("waiting result changed before pop");

endmodule

bind memory_snapshot_value_filter msvf_port_checks u_msvf_port_checks (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .match_address (match_address),
  .hit           (hit),
  .run_end       (run_end)
);
